@@ rtl/ppq_pkg.sv @@
package ppq_pkg;

    localparam int W_COORD = 32;
    localparam int W_CFG   = 31;
    localparam int W_IDX   = 8;
    localparam int W_DATA  = 32;
    localparam int FRAC    = 16;

    localparam logic [W_IDX-1:0] CFG_THRESHOLD = W_IDX'(0);
    localparam logic [W_IDX-1:0] CFG_WEIGHT    = W_IDX'(1);

    localparam logic [W_CFG-1:0] THRESHOLD_RST = W_CFG'(65536);
    localparam logic [W_CFG-1:0] WEIGHT_RST    = W_CFG'(65536);

    // operand widths after squaring, cubing and raising a distance to the fourth power, and of a sum of squares
    localparam int W_SQ   = 2 * W_CFG;
    localparam int W_CUBE = 3 * W_CFG;
    localparam int W_NUM  = 4 * W_CFG;
    localparam int W_SUM  = 2 * W_COORD + 1;

    localparam int MUL_CHUNK = 32;
    localparam int QUO_BITS  = 32;
    localparam int LAT_MUL   = 2;
    localparam int LAT_SQRT  = W_CFG;
    localparam int LAT_DIV   = QUO_BITS + 2;
    localparam int LATENCY   = 7 + 3 * LAT_MUL + LAT_SQRT + LAT_DIV;

    localparam int N_LANES  = 5;
    localparam int LANE_GX  = 0;
    localparam int LANE_GY  = 1;
    localparam int LANE_HXX = 2;
    localparam int LANE_HYY = 3;
    localparam int LANE_HXY = 4;

    typedef struct packed {
        logic dx_pos;
        logic dx_neg;
        logic dy_pos;
        logic dy_neg;
    } t_sgn;

    typedef struct packed {
        logic [W_COORD-1:0] ax;
        logic [W_COORD-1:0] ay;
        t_sgn               sgn;
    } t_geo;

    typedef struct packed {
        logic [W_CFG-1:0] ax;
        logic [W_CFG-1:0] ay;
        logic [W_SQ-1:0]  x2;
        logic [W_SQ-1:0]  y2;
        logic [W_SQ-1:0]  xy;
        t_sgn             sgn;
        logic             active;
        logic             coinc;
    } t_sqp;

    typedef struct packed {
        logic [W_CFG-1:0] d;
        logic [W_CFG-1:0] ax;
        logic [W_CFG-1:0] ay;
        t_sgn             sgn;
        logic             active;
        logic             coinc;
    } t_r1;

    typedef struct packed {
        logic [W_CFG-1:0] d;
        logic [W_NUM-1:0] hxy_n;
        t_sgn             sgn;
        logic             active;
        logic             coinc;
        logic             hxx_neg;
        logic             hyy_neg;
    } t_r2;

    typedef struct packed {
        logic              active;
        logic              coinc;
        logic [W_DATA-1:0] cost;
    } t_res;

endpackage

@@ rtl/ppq_mul.sv @@
module ppq_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             i_clk,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p
);

    localparam int CW  = ppq_pkg::MUL_CHUNK;
    localparam int NA  = (WA + CW - 1) / CW;
    localparam int NB  = (WB + CW - 1) / CW;
    localparam int WAP = NA * CW;
    localparam int WBP = NB * CW;
    localparam int WP  = WA + WB;

    logic [WAP-1:0]    a_pad;
    logic [WBP-1:0]    b_pad;
    logic [2*CW-1:0]   r_pp [NA][NB];
    logic [WP-1:0]     n_p;
    logic [WP-1:0]     r_p;

    assign a_pad = WAP'(i_a);
    assign b_pad = WBP'(i_b);

    // partial products of 32-bit chunks
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_p = n_p + (WP'(r_pp[i][j]) << (CW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

@@ rtl/ppq_sqrt.sv @@
module ppq_sqrt #(
    parameter int NB = 31,
    parameter int WP = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*NB-1:0] i_s,
    input  logic [WP-1:0]   i_pay,
    output logic            o_valid,
    output logic [NB-1:0]   o_root,
    output logic [WP-1:0]   o_pay
);

    localparam int WS = 2 * NB;

    logic          r_v   [NB];
    logic [WS-1:0] r_rem [NB];
    logic [NB-1:0] r_q   [NB];
    logic [WP-1:0] r_pay [NB];

    // one root bit per stage, most significant first
    for (genvar k = 0; k < NB; k++) begin : g_stage
        localparam int I = NB - 1 - k;
        logic          p_v;
        logic [WS-1:0] p_rem;
        logic [NB-1:0] p_q;
        logic [WP-1:0] p_pay;
        logic [WS-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = i_s;
            assign p_q   = '0;
            assign p_pay = i_pay;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_q   = r_q[k-1];
            assign p_pay = r_pay[k-1];
        end

        // (q + 2^i)^2 - q^2
        assign trial = (WS'(p_q) << (I + 1)) | (WS'(1) << (2 * I));
        assign ge    = p_rem >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? p_rem - trial : p_rem;
            r_q[k]   <= ge ? (p_q | (NB'(1) << I)) : p_q;
            r_pay[k] <= p_pay;
        end
    end

    assign o_valid = r_v[NB-1];
    assign o_root  = r_q[NB-1];
    assign o_pay   = r_pay[NB-1];

endmodule

@@ rtl/ppq_div.sv @@
module ppq_div #(
    parameter int LANES = 5,
    parameter int WN    = 124,
    parameter int WD    = 93,
    parameter int QB    = 32,
    parameter int WP    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [LANES-1:0][WN-1:0]   i_num,
    input  logic [LANES-1:0][WD-1:0]   i_den,
    input  logic [LANES-1:0]           i_neg,
    input  logic [WP-1:0]              i_pay,
    output logic                       o_valid,
    output logic [LANES-1:0][QB-1:0]   o_q,
    output logic [WP-1:0]              o_pay
);

    localparam int WH = WN - QB;
    localparam int WC = (WH > WD) ? WH : WD;
    localparam logic [QB-1:0] MIN_PAT = {1'b1, {(QB-1){1'b0}}};
    localparam logic [QB-1:0] MAX_PAT = ~MIN_PAT;

    logic                     r_v   [QB+1];
    logic [LANES-1:0][WD-1:0] r_rem [QB+1];
    logic [LANES-1:0][QB-1:0] r_q   [QB+1];
    logic [LANES-1:0][QB-1:0] r_nlo [QB+1];
    logic [LANES-1:0][WD-1:0] r_den [QB+1];
    logic [LANES-1:0]         r_neg [QB+1];
    logic [LANES-1:0]         r_ovf [QB+1];
    logic [WP-1:0]            r_pay [QB+1];

    logic                     r_out_v;
    logic [LANES-1:0][QB-1:0] r_out_q;
    logic [WP-1:0]            r_out_pay;
    logic [LANES-1:0][QB-1:0] n_out_q;

    // entry: a quotient of 2^QB or more saturates whatever the sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_ovf[0][l] <= WC'(i_num[l][WN-1:QB]) >= WC'(i_den[l]);
            r_rem[0][l] <= WD'(i_num[l][WN-1:QB]);
            r_nlo[0][l] <= i_num[l][QB-1:0];
        end
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        r_pay[0] <= i_pay;
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [LANES-1:0][WD-1:0] n_rem;
        logic [LANES-1:0][QB-1:0] n_q;
        logic [WD:0]              trial [LANES];
        logic [LANES-1:0]         ge;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {r_rem[k-1][l], r_nlo[k-1][l][QB-1]};
                ge[l]    = trial[l] >= {1'b0, r_den[k-1][l]};
                n_rem[l] = ge[l] ? WD'(trial[l] - {1'b0, r_den[k-1][l]}) : WD'(trial[l]);
                n_q[l]   = {r_q[k-1][l][QB-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_q[k]   <= n_q;
            for (int l = 0; l < LANES; l++) begin
                r_nlo[k][l] <= r_nlo[k-1][l] << 1;
            end
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_pay[k] <= r_pay[k-1];
        end
    end

    // sign and saturate to a 32-bit pattern
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_neg[QB][l]) begin
                if (r_ovf[QB][l] || (r_q[QB][l][QB-1] && |r_q[QB][l][QB-2:0])) begin
                    n_out_q[l] = MIN_PAT;
                end else begin
                    n_out_q[l] = QB'(0) - r_q[QB][l];
                end
            end else begin
                if (r_ovf[QB][l] || r_q[QB][l][QB-1]) begin
                    n_out_q[l] = MAX_PAT;
                end else begin
                    n_out_q[l] = r_q[QB][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_q   <= n_out_q;
        r_out_pay <= r_pay[QB];
    end

    assign o_valid = r_out_v;
    assign o_q     = r_out_q;
    assign o_pay   = r_out_pay;

endmodule

@@ rtl/proximity_penalty_quadratic.sv @@
// channel  dir  accepted when                 words
// start    in   start & !busy                 i_first_x i_first_y i_second_x i_second_y
// result   out  o_valid, one cycle, no stall  o_active o_degenerate o_cost o_grad_* o_hess_*
// config   in   i_cfg_valid & o_cfg_ready     i_cfg_index i_cfg_data
//
// one item per cycle, every cycle; busy stays low
// a 31-stage square root and a 34-stage divider dominate the latency
// the result of an item appears on o_valid exactly once, in accept order
// reset clears the pipeline valids and sets threshold and weight to 1.0
// the result side cannot stall, so the pipeline never holds
module proximity_penalty_quadratic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ppq_pkg::W_COORD-1:0]  i_first_x,
    input  logic signed [ppq_pkg::W_COORD-1:0]  i_first_y,
    input  logic signed [ppq_pkg::W_COORD-1:0]  i_second_x,
    input  logic signed [ppq_pkg::W_COORD-1:0]  i_second_y,
    output logic                                o_valid,
    output logic                                o_active,
    output logic                                o_degenerate,
    output logic        [ppq_pkg::W_DATA-1:0]   o_cost,
    output logic signed [ppq_pkg::W_DATA-1:0]   o_grad_x,
    output logic signed [ppq_pkg::W_DATA-1:0]   o_grad_y,
    output logic signed [ppq_pkg::W_DATA-1:0]   o_hess_xx,
    output logic signed [ppq_pkg::W_DATA-1:0]   o_hess_yy,
    output logic signed [ppq_pkg::W_DATA-1:0]   o_hess_xy,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [ppq_pkg::W_IDX-1:0]    i_cfg_index,
    input  logic        [ppq_pkg::W_DATA-1:0]   i_cfg_data
);

    localparam int WC  = ppq_pkg::W_COORD;
    localparam int WT  = ppq_pkg::W_CFG;
    localparam int WSQ = ppq_pkg::W_SQ;
    localparam int WCB = ppq_pkg::W_CUBE;
    localparam int WNM = ppq_pkg::W_NUM;
    localparam int WS  = ppq_pkg::W_SUM;
    localparam int WO  = ppq_pkg::W_DATA;
    localparam int LM  = ppq_pkg::LAT_MUL;
    localparam int NL  = ppq_pkg::N_LANES;

    // configuration
    logic [WT-1:0]  r_thr;
    logic [WT-1:0]  r_wgt;
    logic [WSQ-1:0] r_t2;
    logic [WSQ-1:0] r_wt;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ppq_pkg::THRESHOLD_RST;
            r_wgt <= ppq_pkg::WEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ppq_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[WT-1:0];
                ppq_pkg::CFG_WEIGHT:    r_wgt <= i_cfg_data[WT-1:0];
                default: ;
            endcase
        end
    end

    // derived constants, registered from threshold and weight; items are not held while they settle
    always_ff @(posedge i_clk) begin
        r_t2 <= r_thr * r_thr;
        r_wt <= r_wgt * r_thr;
    end

    // stage 1: differences and magnitudes
    logic [WC:0]       n_dx;
    logic [WC:0]       n_dy;
    logic [WC:0]       n_dxm;
    logic [WC:0]       n_dym;
    ppq_pkg::t_geo     n_geo;
    logic              r1_v;
    ppq_pkg::t_geo     r1_geo;

    always_comb begin
        n_dx  = {i_first_x[WC-1], i_first_x} - {i_second_x[WC-1], i_second_x};
        n_dy  = {i_first_y[WC-1], i_first_y} - {i_second_y[WC-1], i_second_y};
        n_dxm = (WC+1)'(0) - n_dx;
        n_dym = (WC+1)'(0) - n_dy;
        n_geo.ax = n_dx[WC] ? n_dxm[WC-1:0] : n_dx[WC-1:0];
        n_geo.ay = n_dy[WC] ? n_dym[WC-1:0] : n_dy[WC-1:0];
        n_geo.sgn.dx_neg = n_dx[WC];
        n_geo.sgn.dy_neg = n_dy[WC];
        n_geo.sgn.dx_pos = !n_dx[WC] && (n_dx != '0);
        n_geo.sgn.dy_pos = !n_dy[WC] && (n_dy != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_geo <= n_geo;
    end

    // squares and cross product
    logic [2*WC-1:0] m_x2;
    logic [2*WC-1:0] m_y2;
    logic [2*WC-1:0] m_xy;

    ppq_mul #(.WA(WC), .WB(WC)) u_mul_x2 (
        .i_clk (i_clk), .i_a (r1_geo.ax), .i_b (r1_geo.ax), .o_p (m_x2)
    );
    ppq_mul #(.WA(WC), .WB(WC)) u_mul_y2 (
        .i_clk (i_clk), .i_a (r1_geo.ay), .i_b (r1_geo.ay), .o_p (m_y2)
    );
    ppq_mul #(.WA(WC), .WB(WC)) u_mul_xy (
        .i_clk (i_clk), .i_a (r1_geo.ax), .i_b (r1_geo.ay), .o_p (m_xy)
    );

    logic          r_a_v   [LM];
    ppq_pkg::t_geo r_a_geo [LM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LM; k++) begin
                r_a_v[k] <= 1'b0;
            end
        end else begin
            r_a_v[0] <= r1_v;
            for (int k = 1; k < LM; k++) begin
                r_a_v[k] <= r_a_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_geo[0] <= r1_geo;
        for (int k = 1; k < LM; k++) begin
            r_a_geo[k] <= r_a_geo[k-1];
        end
    end

    // stage 4: sum of squares and per-axis threshold compare
    logic          r4_v;
    logic [WS-1:0] r4_s;
    logic          r4_lt;
    logic [WSQ-1:0] r4_x2;
    logic [WSQ-1:0] r4_y2;
    logic [WSQ-1:0] r4_xy;
    ppq_pkg::t_geo r4_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r_a_v[LM-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r4_s   <= {1'b0, m_x2} + {1'b0, m_y2};
        r4_lt  <= (r_a_geo[LM-1].ax < WC'(r_thr)) && (r_a_geo[LM-1].ay < WC'(r_thr));
        r4_x2  <= m_x2[WSQ-1:0];
        r4_y2  <= m_y2[WSQ-1:0];
        r4_xy  <= m_xy[WSQ-1:0];
        r4_geo <= r_a_geo[LM-1];
    end

    // stage 5: threshold test and coincidence test
    logic            r5_v;
    logic [WSQ-1:0]  r5_s;
    ppq_pkg::t_sqp   r5_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_s          <= r4_s[WSQ-1:0];
        r5_p.ax       <= r4_geo.ax[WT-1:0];
        r5_p.ay       <= r4_geo.ay[WT-1:0];
        r5_p.x2       <= r4_x2;
        r5_p.y2       <= r4_y2;
        r5_p.xy       <= r4_xy;
        r5_p.sgn      <= r4_geo.sgn;
        r5_p.active   <= r4_lt && (r4_s < WS'(r_t2));
        r5_p.coinc    <= r4_s == '0;
    end

    // square root
    logic            sq_v;
    logic [WT-1:0]   sq_d;
    ppq_pkg::t_sqp   sq_p;

    ppq_sqrt #(.NB(WT), .WP($bits(ppq_pkg::t_sqp))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_s     (r5_s),
        .i_pay   (r5_p),
        .o_valid (sq_v),
        .o_root  (sq_d),
        .o_pay   (sq_p)
    );

    // stage g: gap to threshold
    logic          rg_v;
    logic [WT-1:0] rg_d;
    logic [WT-1:0] rg_g;
    ppq_pkg::t_sqp rg_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rg_v <= 1'b0;
        end else begin
            rg_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        rg_d <= sq_d;
        rg_g <= r_thr - sq_d;
        rg_p <= sq_p;
    end

    // first round of products
    logic [WSQ-1:0] m_gg;
    logic [WSQ-1:0] m_wg;
    logic [WSQ-1:0] m_dd;
    logic [WCB-1:0] m_xd;
    logic [WCB-1:0] m_gy;
    logic [WCB-1:0] m_yd;
    logic [WCB-1:0] m_gx;
    logic [WNM-1:0] m_hxy;

    ppq_mul #(.WA(WT), .WB(WT)) u_mul_gg (
        .i_clk (i_clk), .i_a (rg_g), .i_b (rg_g), .o_p (m_gg)
    );
    ppq_mul #(.WA(WT), .WB(WT)) u_mul_wg (
        .i_clk (i_clk), .i_a (r_wgt), .i_b (rg_g), .o_p (m_wg)
    );
    ppq_mul #(.WA(WT), .WB(WT)) u_mul_dd (
        .i_clk (i_clk), .i_a (rg_d), .i_b (rg_d), .o_p (m_dd)
    );
    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_xd (
        .i_clk (i_clk), .i_a (rg_p.x2), .i_b (rg_d), .o_p (m_xd)
    );
    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_gy (
        .i_clk (i_clk), .i_a (rg_p.y2), .i_b (rg_g), .o_p (m_gy)
    );
    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_yd (
        .i_clk (i_clk), .i_a (rg_p.y2), .i_b (rg_d), .o_p (m_yd)
    );
    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_gx (
        .i_clk (i_clk), .i_a (rg_p.x2), .i_b (rg_g), .o_p (m_gx)
    );
    ppq_mul #(.WA(WSQ), .WB(WSQ)) u_mul_hxy (
        .i_clk (i_clk), .i_a (r_wt), .i_b (rg_p.xy), .o_p (m_hxy)
    );

    logic         r_b_v    [LM];
    ppq_pkg::t_r1 r_b_side [LM];
    ppq_pkg::t_r1 n_b_side;

    always_comb begin
        n_b_side.d      = rg_d;
        n_b_side.ax     = rg_p.ax;
        n_b_side.ay     = rg_p.ay;
        n_b_side.sgn    = rg_p.sgn;
        n_b_side.active = rg_p.active;
        n_b_side.coinc  = rg_p.coinc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LM; k++) begin
                r_b_v[k] <= 1'b0;
            end
        end else begin
            r_b_v[0] <= rg_v;
            for (int k = 1; k < LM; k++) begin
                r_b_v[k] <= r_b_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_side[0] <= n_b_side;
        for (int k = 1; k < LM; k++) begin
            r_b_side[k] <= r_b_side[k-1];
        end
    end

    // stage p: signed differences of the hessian diagonal
    logic           rp_v;
    logic [WSQ-1:0] rp_gg;
    logic [WSQ-1:0] rp_wg;
    logic [WSQ-1:0] rp_dd;
    logic [WCB-1:0] rp_hxx;
    logic [WCB-1:0] rp_hyy;
    logic [WT-1:0]  rp_ax;
    logic [WT-1:0]  rp_ay;
    ppq_pkg::t_r2   rp_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_v <= 1'b0;
        end else begin
            rp_v <= r_b_v[LM-1];
        end
    end

    always_ff @(posedge i_clk) begin
        rp_gg           <= m_gg;
        rp_wg           <= m_wg;
        rp_dd           <= m_dd;
        rp_hxx          <= (m_xd >= m_gy) ? m_xd - m_gy : m_gy - m_xd;
        rp_hyy          <= (m_yd >= m_gx) ? m_yd - m_gx : m_gx - m_yd;
        rp_ax           <= r_b_side[LM-1].ax;
        rp_ay           <= r_b_side[LM-1].ay;
        rp_side.d       <= r_b_side[LM-1].d;
        rp_side.hxy_n   <= m_hxy;
        rp_side.sgn     <= r_b_side[LM-1].sgn;
        rp_side.active  <= r_b_side[LM-1].active;
        rp_side.coinc   <= r_b_side[LM-1].coinc;
        rp_side.hxx_neg <= m_xd < m_gy;
        rp_side.hyy_neg <= m_yd < m_gx;
    end

    // second round of products
    logic [WCB-1:0] m_cost;
    logic [WCB-1:0] m_gnx;
    logic [WCB-1:0] m_gny;
    logic [WCB-1:0] m_d3;
    logic [WNM-1:0] m_hxx;
    logic [WNM-1:0] m_hyy;

    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_cost (
        .i_clk (i_clk), .i_a (rp_gg), .i_b (r_wgt), .o_p (m_cost)
    );
    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_gnx (
        .i_clk (i_clk), .i_a (rp_wg), .i_b (rp_ax), .o_p (m_gnx)
    );
    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_gny (
        .i_clk (i_clk), .i_a (rp_wg), .i_b (rp_ay), .o_p (m_gny)
    );
    ppq_mul #(.WA(WSQ), .WB(WT)) u_mul_d3 (
        .i_clk (i_clk), .i_a (rp_dd), .i_b (rp_side.d), .o_p (m_d3)
    );
    ppq_mul #(.WA(WCB), .WB(WT)) u_mul_hxx (
        .i_clk (i_clk), .i_a (rp_hxx), .i_b (r_wgt), .o_p (m_hxx)
    );
    ppq_mul #(.WA(WCB), .WB(WT)) u_mul_hyy (
        .i_clk (i_clk), .i_a (rp_hyy), .i_b (r_wgt), .o_p (m_hyy)
    );

    logic         r_c_v    [LM];
    ppq_pkg::t_r2 r_c_side [LM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LM; k++) begin
                r_c_v[k] <= 1'b0;
            end
        end else begin
            r_c_v[0] <= rp_v;
            for (int k = 1; k < LM; k++) begin
                r_c_v[k] <= r_c_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_side[0] <= rp_side;
        for (int k = 1; k < LM; k++) begin
            r_c_side[k] <= r_c_side[k-1];
        end
    end

    // stage c: cost and divider operands
    logic                  rc_v;
    logic [NL-1:0][WNM-1:0] rc_num;
    logic [NL-1:0][WCB-1:0] rc_den;
    logic [NL-1:0]          rc_neg;
    ppq_pkg::t_res          rc_res;
    logic [WCB-34:0]        n_cost_hi;
    ppq_pkg::t_r2           c_side;

    assign c_side    = r_c_side[LM-1];
    // cost is w*g^2 / 2^33
    assign n_cost_hi = m_cost[WCB-1:33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_v <= 1'b0;
        end else begin
            rc_v <= r_c_v[LM-1];
        end
    end

    always_ff @(posedge i_clk) begin
        rc_num[ppq_pkg::LANE_GX]  <= WNM'(m_gnx);
        rc_num[ppq_pkg::LANE_GY]  <= WNM'(m_gny);
        rc_num[ppq_pkg::LANE_HXX] <= m_hxx;
        rc_num[ppq_pkg::LANE_HYY] <= m_hyy;
        rc_num[ppq_pkg::LANE_HXY] <= c_side.hxy_n;
        rc_den[ppq_pkg::LANE_GX]  <= WCB'({c_side.d, {ppq_pkg::FRAC{1'b0}}});
        rc_den[ppq_pkg::LANE_GY]  <= WCB'({c_side.d, {ppq_pkg::FRAC{1'b0}}});
        rc_den[ppq_pkg::LANE_HXX] <= m_d3;
        rc_den[ppq_pkg::LANE_HYY] <= m_d3;
        rc_den[ppq_pkg::LANE_HXY] <= m_d3;
        rc_neg[ppq_pkg::LANE_GX]  <= c_side.sgn.dx_pos;
        rc_neg[ppq_pkg::LANE_GY]  <= c_side.sgn.dy_pos;
        rc_neg[ppq_pkg::LANE_HXX] <= c_side.hxx_neg;
        rc_neg[ppq_pkg::LANE_HYY] <= c_side.hyy_neg;
        rc_neg[ppq_pkg::LANE_HXY] <= c_side.sgn.dx_neg != c_side.sgn.dy_neg;
        rc_res.active <= c_side.active;
        rc_res.coinc  <= c_side.coinc;
        rc_res.cost   <= (|n_cost_hi[WCB-34:WO]) ? '1 : n_cost_hi[WO-1:0];
    end

    // dividers
    logic                   dv_v;
    logic [NL-1:0][WO-1:0]  dv_q;
    ppq_pkg::t_res          dv_res;

    ppq_div #(
        .LANES (NL),
        .WN    (WNM),
        .WD    (WCB),
        .QB    (ppq_pkg::QUO_BITS),
        .WP    ($bits(ppq_pkg::t_res))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rc_v),
        .i_num   (rc_num),
        .i_den   (rc_den),
        .i_neg   (rc_neg),
        .i_pay   (rc_res),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_pay   (dv_res)
    );

    // output register
    logic          r_o_v;
    logic          r_o_active;
    logic          r_o_degen;
    logic [WO-1:0] r_o_cost;
    logic [NL-1:0][WO-1:0] r_o_terms;
    logic          n_terms_on;

    assign n_terms_on = dv_res.active && !dv_res.coinc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_active <= dv_res.active;
        r_o_degen  <= dv_res.active && dv_res.coinc;
        r_o_cost   <= dv_res.active ? dv_res.cost : '0;
        r_o_terms  <= n_terms_on ? dv_q : '0;
    end

    assign o_valid      = r_o_v;
    assign o_active     = r_o_active;
    assign o_degenerate = r_o_degen;
    assign o_cost       = r_o_cost;
    assign o_grad_x     = $signed(r_o_terms[ppq_pkg::LANE_GX]);
    assign o_grad_y     = $signed(r_o_terms[ppq_pkg::LANE_GY]);
    assign o_hess_xx    = $signed(r_o_terms[ppq_pkg::LANE_HXX]);
    assign o_hess_yy    = $signed(r_o_terms[ppq_pkg::LANE_HYY]);
    assign o_hess_xy    = $signed(r_o_terms[ppq_pkg::LANE_HXY]);

endmodule

@@ rtl/ppq_chk.sv @@
module ppq_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic                               o_active,
    input logic                               o_degenerate,
    input logic        [ppq_pkg::W_DATA-1:0]  o_cost,
    input logic signed [ppq_pkg::W_DATA-1:0]  o_grad_x,
    input logic signed [ppq_pkg::W_DATA-1:0]  o_grad_y,
    input logic signed [ppq_pkg::W_DATA-1:0]  o_hess_xx,
    input logic signed [ppq_pkg::W_DATA-1:0]  o_hess_yy,
    input logic signed [ppq_pkg::W_DATA-1:0]  o_hess_xy
);

    // every result traces back to a word taken a fixed time earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, ppq_pkg::LATENCY))
        else $error("result without a matching accepted word");

    // outside the threshold everything reads zero
    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> !o_degenerate && o_cost == '0 && o_grad_x == '0
            && o_grad_y == '0 && o_hess_xx == '0 && o_hess_yy == '0 && o_hess_xy == '0)
        else $error("inactive result carries nonzero fields");

    // coincident points: active, no gradient or hessian
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_active && o_grad_x == '0 && o_grad_y == '0
            && o_hess_xx == '0 && o_hess_yy == '0 && o_hess_xy == '0)
        else $error("degenerate result carries terms");

endmodule

bind proximity_penalty_quadratic ppq_chk u_ppq_chk (.*);
